// ----- hw/rtl/frr_pkg.sv -----
// Package for the framed record receiver.
// Holds parser phase type, character and event/tag codes, and the result record.
// No dependencies.
package frr_pkg;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_LEN   = 4'd1,
		PH_FMT   = 4'd2,
		PH_WSID  = 4'd3,
		PH_DATE  = 4'd4,
		PH_TIME  = 4'd5,
		PH_SEQ   = 4'd6,
		PH_STEP  = 4'd7,
		PH_STATE = 4'd8,
		PH_DATA  = 4'd9,
		PH_ETX   = 4'd10,
		PH_BCC   = 4'd11
	} frr_phase_t;

	localparam logic [7:0] CH_STX      = 8'h02;
	localparam logic [7:0] CH_ETX      = 8'h03;
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] DIGIT_BASE  = 8'h30;
	localparam logic [7:0] DIGIT_TOP   = 8'h39;
	localparam logic [7:0] STATUS_CHAR = 8'h41;

	localparam logic [9:0] STATUS_LEN = 10'd9;
	localparam logic [9:0] COUNT_MAX  = 10'd1023;
	localparam logic [6:0] STEP_MAX   = 7'd16;
	localparam logic [6:0] SKIP_MARK  = 7'd100;
	localparam logic [6:0] DEAD_MARK  = 7'd101;
	localparam logic [6:0] DIGIT_MAX  = 7'd9;

	localparam logic [2:0] LEN_BYTES  = 3'd3;
	localparam logic [2:0] WSID_BYTES = 3'd5;
	localparam logic [2:0] DATE_BYTES = 3'd6;
	localparam logic [2:0] TIME_BYTES = 3'd6;
	localparam logic [2:0] SEQ_BYTES  = 3'd4;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_ACK    = 2'd1;
	localparam logic [1:0] EV_NAK    = 2'd2;
	localparam logic [1:0] EV_STATUS = 2'd3;

	localparam logic [3:0] TAG_NONE  = 4'd0;
	localparam logic [3:0] TAG_LEN   = 4'd1;
	localparam logic [3:0] TAG_WSID  = 4'd2;
	localparam logic [3:0] TAG_DATE  = 4'd3;
	localparam logic [3:0] TAG_TIME  = 4'd4;
	localparam logic [3:0] TAG_SEQ   = 4'd5;
	localparam logic [3:0] TAG_STEP  = 4'd6;
	localparam logic [3:0] TAG_STATE = 4'd7;
	localparam logic [3:0] TAG_DATA  = 4'd8;

	typedef struct packed {
		logic [1:0] event_res;
		logic [3:0] field_tag;
		logic [7:0] field_byte;
		logic       field_end;
		logic [4:0] photo_step;
		logic       new_cycle;
		logic [9:0] announced_len;
		logic       len_mismatch;
	} frr_result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= DIGIT_BASE) && (c <= DIGIT_TOP);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ----- hw/rtl/frr_parser.sv -----
// Record parser: phase register, check accumulator, counters and photo step.
// Computes the result for the byte on rx_byte; state advances when advance is high.
// Depends on frr_pkg.
module frr_parser import frr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  rx_byte,
	output frr_result_t result
);

	frr_phase_t phase_q, phase_pre, phase_n;
	logic [7:0] acc_q, acc_pre, acc_n;
	logic [9:0] lv_q, lv_n;
	logic [9:0] rc_q, rc_pre, rc_n;
	logic [2:0] fc_q, fc_pre, fc_n;
	logic       sr_q, sr_n;
	logic [6:0] sd_q, sd_n;
	logic [4:0] ls_q, ls_n;

	logic [7:0]  sb;
	logic [3:0]  digit;
	logic [13:0] lv_mul;
	logic [6:0]  step_v;
	logic        step_ok;
	logic        len_status;

	always_comb begin
		sb = (rx_byte == CH_NUL) ? CH_SPACE : rx_byte;
		digit = 4'(sb - DIGIT_BASE);
		lv_mul = 14'(lv_q) * 14'd10 + 14'(digit);
		len_status = (fc_pre == 3'd1) && (rx_byte == STATUS_CHAR);
		step_v = '0;
		if (sd_q <= DIGIT_MAX) begin
			step_v = is_digit(sb) ? 7'(7'(sd_q[3:0]) * 7'd10 + 7'(digit)) : sd_q;
		end else if (sd_q == SKIP_MARK) begin
			step_v = is_digit(sb) ? 7'(digit) : 7'd0;
		end
		step_ok = (step_v >= 7'd1) && (step_v <= STEP_MAX);
	end

	always_comb begin
		phase_pre = phase_q;
		acc_pre = acc_q;
		rc_pre = rc_q;
		fc_pre = fc_q;
		if (rx_byte == CH_STX) begin
			if (phase_q != PH_BCC) phase_pre = PH_IDLE;
		end else if (rx_byte == CH_ETX) begin
			if (phase_q != PH_BCC && phase_q != PH_IDLE) phase_pre = PH_ETX;
		end else if (phase_q != PH_BCC) begin
			if (rc_q != COUNT_MAX) rc_pre = rc_q + 10'd1;
			fc_pre = fc_q + 3'd1;
			acc_pre = acc_q ^ rx_byte;
		end
	end

	always_comb begin
		phase_n = phase_pre;
		acc_n = acc_pre;
		lv_n = lv_q;
		rc_n = rc_pre;
		fc_n = fc_pre;
		sr_n = sr_q;
		sd_n = sd_q;
		ls_n = ls_q;
		unique case (phase_pre)
			PH_IDLE: begin
				if (rx_byte == CH_STX) begin
					acc_n = '0; lv_n = '0; rc_n = '0; fc_n = '0; sr_n = 1'b0; sd_n = '0;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				if (is_digit(rx_byte)) begin
					lv_n = lv_mul[9:0];
					if (fc_pre == LEN_BYTES) begin
						fc_n = '0;
						phase_n = PH_FMT;
					end
				end else if (len_status) begin
					sr_n = 1'b1;
					phase_n = PH_ETX;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_FMT: begin
				fc_n = '0;
				phase_n = PH_WSID;
			end
			PH_WSID: begin
				if (fc_pre == WSID_BYTES) begin
					fc_n = '0;
					phase_n = PH_DATE;
				end
			end
			PH_DATE: begin
				if (fc_pre == DATE_BYTES) begin
					fc_n = '0;
					phase_n = PH_TIME;
				end
			end
			PH_TIME: begin
				if (fc_pre == TIME_BYTES) begin
					fc_n = '0;
					phase_n = PH_SEQ;
				end
			end
			PH_SEQ: begin
				if (fc_pre == SEQ_BYTES) begin
					fc_n = '0;
					phase_n = PH_STEP;
				end
			end
			PH_STEP: begin
				if (fc_pre <= 3'd1) begin
					if (is_digit(sb)) sd_n = 7'(digit);
					else if (is_space(sb) || sb == CH_PLUS) sd_n = SKIP_MARK;
					else sd_n = DEAD_MARK;
				end else begin
					ls_n = step_ok ? step_v[4:0] : 5'd0;
					fc_n = '0;
					phase_n = PH_STATE;
				end
			end
			PH_STATE: begin
				fc_n = '0;
				phase_n = PH_DATA;
			end
			PH_DATA: begin
				if (rc_pre > lv_q) phase_n = PH_BCC;
			end
			PH_ETX: begin
				if (rx_byte == CH_ETX) begin
					acc_n = acc_pre ^ rx_byte;
					phase_n = PH_BCC;
				end else if (rc_pre == STATUS_LEN) begin
					phase_n = PH_BCC;
				end
			end
			PH_BCC: begin
				if (acc_pre == rx_byte) begin
					acc_n = '0; lv_n = '0; rc_n = '0; fc_n = '0; sr_n = 1'b0; sd_n = '0;
				end
				phase_n = PH_IDLE;
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	always_comb begin
		result = '0;
		result.photo_step = ls_n;
		result.announced_len = lv_n;
		unique case (phase_pre)
			PH_LEN: begin
				result.field_tag = TAG_LEN;
				if (is_digit(rx_byte)) result.field_end = (fc_pre == LEN_BYTES);
				else if (!len_status) result.event_res = EV_NAK;
			end
			PH_WSID: begin
				result.field_tag = TAG_WSID;
				result.field_end = (fc_pre == WSID_BYTES);
			end
			PH_DATE: begin
				result.field_tag = TAG_DATE;
				result.field_end = (fc_pre == DATE_BYTES);
			end
			PH_TIME: begin
				result.field_tag = TAG_TIME;
				result.field_end = (fc_pre == TIME_BYTES);
			end
			PH_SEQ: begin
				result.field_tag = TAG_SEQ;
				result.field_end = (fc_pre == SEQ_BYTES);
			end
			PH_STEP: begin
				result.field_tag = TAG_STEP;
				if (fc_pre > 3'd1) begin
					result.field_end = 1'b1;
					result.new_cycle = step_ok && (step_v < 7'(ls_q));
				end
			end
			PH_STATE: begin
				result.field_tag = TAG_STATE;
				result.field_end = 1'b1;
			end
			PH_DATA: result.field_tag = TAG_DATA;
			PH_BCC: begin
				if (acc_pre != rx_byte) begin
					result.event_res = EV_NAK;
				end else if (sr_q) begin
					result.event_res = EV_STATUS;
				end else begin
					result.event_res = EV_ACK;
					result.len_mismatch = (rc_pre != lv_q);
				end
			end
			default: result.field_tag = TAG_NONE;
		endcase
		result.field_byte = (result.field_tag != TAG_NONE) ? sb : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= '0;
			lv_q <= '0;
			rc_q <= '0;
			fc_q <= '0;
			sr_q <= 1'b0;
			sd_q <= '0;
			ls_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			acc_q <= acc_n;
			lv_q <= lv_n;
			rc_q <= rc_n;
			fc_q <= fc_n;
			sr_q <= sr_n;
			sd_q <= sd_n;
			ls_q <= ls_n;
		end
	end

endmodule

// ----- hw/rtl/framed_record_receiver.sv -----
// Framed record receiver top level: byte input channel, parser and result buffer.
// Results are registered: each goes to the output register, or to a skid register while out_stall holds it.
// Throughput: one byte per cycle while in_stall is low; a second register holds one result while out_stall is high.
// Reset: asynchronous, clears the parser to wait for STX and empties both result registers.
// Depends on frr_pkg and frr_parser.
module framed_record_receiver import frr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [3:0] field_tag,
	output logic [7:0] field_byte,
	output logic       field_end,
	output logic [4:0] photo_step,
	output logic       new_cycle,
	output logic [9:0] announced_len,
	output logic       len_mismatch
);

	frr_result_t res, out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        accept, take;

	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign take = out_valid_q && !out_stall;

	frr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.rx_byte (rx_byte),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			out_valid_q <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_q.event_res;
	assign field_tag = out_q.field_tag;
	assign field_byte = out_q.field_byte;
	assign field_end = out_q.field_end;
	assign photo_step = out_q.photo_step;
	assign new_cycle = out_q.new_cycle;
	assign announced_len = out_q.announced_len;
	assign len_mismatch = out_q.len_mismatch;

endmodule

// ----- tb/tb_framed_record_receiver.sv -----
// Self-checking testbench for framed_record_receiver: STX/ETX record parsing, XOR block check,
// photo step tracking and ACK/NAK/status responses, against an in-bench byte-level predictor.
// Depends on frr_pkg and the framed_record_receiver RTL.
module tb_framed_record_receiver;
	import frr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BODY_FIXED = int'(WSID_BYTES) + int'(DATE_BYTES) + int'(TIME_BYTES)
		+ int'(SEQ_BYTES);
	localparam int HEADER_BYTES = int'(LEN_BYTES) + 1 + BODY_FIXED + 3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	typedef enum logic [2:0] {
		SF_TWO_DIGIT,
		SF_LEAD_BLANK,
		SF_TRAIL_JUNK,
		SF_JUNK,
		SF_RANDOM
	} step_form_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] event_res;
	logic [3:0] field_tag;
	logic [7:0] field_byte;
	logic       field_end;
	logic [4:0] photo_step;
	logic       new_cycle;
	logic [9:0] announced_len;
	logic       len_mismatch;

	framed_record_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.field_tag(field_tag),
		.field_byte(field_byte),
		.field_end(field_end),
		.photo_step(photo_step),
		.new_cycle(new_cycle),
		.announced_len(announced_len),
		.len_mismatch(len_mismatch)
	);

	// predictor state
	frr_phase_t rec_phase;
	logic [7:0] bcc_acc;
	logic [9:0] rec_len;
	logic [9:0] rx_count;
	logic [2:0] fld_count;
	logic       status_flag;
	logic [6:0] step_acc;
	logic [4:0] prev_step;

	frr_result_t predicted_out[$];
	frr_result_t got_res;
	frr_result_t want_res;
	logic [7:0]  frame_bytes[$];
	logic [7:0]  frame_acc;

	stall_mode_t stall_mode;
	bit          gap_on;
	int          burst_left;
	int          stall_tick;
	int          cycle_count;
	int          err_count;
	int          bytes_sent;
	int          frames_sent;
	int          results_checked;
	int          ack_seen;
	int          nak_seen;
	int          status_seen;
	int          restart_seen;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic char_numeral(input logic [7:0] c);
		return c >= DIGIT_BASE && c <= DIGIT_TOP;
	endfunction

	function automatic logic char_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void clear_record();
		bcc_acc = '0;
		rec_len = '0;
		rx_count = '0;
		fld_count = '0;
		status_flag = 1'b0;
		step_acc = '0;
	endfunction

	function automatic logic close_field(input logic [2:0] n, input frr_phase_t nxt);
		if (fld_count == n) begin
			fld_count = '0;
			rec_phase = nxt;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic frr_result_t parse_byte(input logic [7:0] b);
		logic [7:0]  sb;
		frr_result_t r;
		int          v;
		sb = (b == CH_NUL) ? CH_SPACE : b;
		r = '0;
		if (b == CH_STX) begin
			if (rec_phase != PH_BCC)
				rec_phase = PH_IDLE;
		end else if (b == CH_ETX) begin
			if (rec_phase != PH_BCC && rec_phase != PH_IDLE)
				rec_phase = PH_ETX;
		end else if (rec_phase != PH_BCC) begin
			if (rx_count != COUNT_MAX)
				rx_count = rx_count + 10'd1;
			fld_count = fld_count + 3'd1;
			bcc_acc = bcc_acc ^ b;
		end
		case (rec_phase)
			PH_IDLE: begin
				if (b == CH_STX) begin
					clear_record();
					rec_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				r.field_tag = TAG_LEN;
				if (char_numeral(b)) begin
					v = int'(rec_len) * 10 + int'(b - DIGIT_BASE);
					rec_len = v[9:0];
					r.field_end = close_field(LEN_BYTES, PH_FMT);
				end else if (fld_count == 3'd1 && b == STATUS_CHAR) begin
					status_flag = 1'b1;
					rec_phase = PH_ETX;
				end else begin
					r.event_res = EV_NAK;
					rec_phase = PH_IDLE;
				end
			end
			PH_FMT: begin
				fld_count = '0;
				rec_phase = PH_WSID;
			end
			PH_WSID: begin
				r.field_tag = TAG_WSID;
				r.field_end = close_field(WSID_BYTES, PH_DATE);
			end
			PH_DATE: begin
				r.field_tag = TAG_DATE;
				r.field_end = close_field(DATE_BYTES, PH_TIME);
			end
			PH_TIME: begin
				r.field_tag = TAG_TIME;
				r.field_end = close_field(TIME_BYTES, PH_SEQ);
			end
			PH_SEQ: begin
				r.field_tag = TAG_SEQ;
				r.field_end = close_field(SEQ_BYTES, PH_STEP);
			end
			PH_STEP: begin
				r.field_tag = TAG_STEP;
				if (fld_count <= 3'd1) begin
					if (char_numeral(sb))
						step_acc = 7'(sb - DIGIT_BASE);
					else if (char_blank(sb) || sb == CH_PLUS)
						step_acc = SKIP_MARK;
					else
						step_acc = DEAD_MARK;
				end else begin
					v = 0;
					if (step_acc <= DIGIT_MAX)
						v = char_numeral(sb) ? int'(step_acc) * 10 + int'(sb - DIGIT_BASE)
							: int'(step_acc);
					else if (step_acc == SKIP_MARK)
						v = char_numeral(sb) ? int'(sb - DIGIT_BASE) : 0;
					if (v >= 1 && v <= int'(STEP_MAX)) begin
						if (v < int'(prev_step))
							r.new_cycle = 1'b1;
						prev_step = v[4:0];
					end else begin
						prev_step = '0;
					end
					r.field_end = 1'b1;
					fld_count = '0;
					rec_phase = PH_STATE;
				end
			end
			PH_STATE: begin
				r.field_tag = TAG_STATE;
				r.field_end = 1'b1;
				fld_count = '0;
				rec_phase = PH_DATA;
			end
			PH_DATA: begin
				r.field_tag = TAG_DATA;
				if (rx_count > rec_len)
					rec_phase = PH_BCC;
			end
			PH_ETX: begin
				if (b == CH_ETX) begin
					bcc_acc = bcc_acc ^ CH_ETX;
					rec_phase = PH_BCC;
				end else if (rx_count == STATUS_LEN) begin
					rec_phase = PH_BCC;
				end
			end
			PH_BCC: begin
				if (bcc_acc != b) begin
					r.event_res = EV_NAK;
				end else if (status_flag) begin
					r.event_res = EV_STATUS;
					clear_record();
				end else begin
					r.event_res = EV_ACK;
					r.len_mismatch = (rx_count != rec_len);
					clear_record();
				end
				rec_phase = PH_IDLE;
			end
			default: rec_phase = PH_IDLE;
		endcase
		r.field_byte = (r.field_tag != TAG_NONE) ? sb : 8'h00;
		r.photo_step = prev_step;
		r.announced_len = rec_len;
		return r;
	endfunction

	always @(negedge clk) begin
		stall_tick = stall_tick + 1;
		case (stall_mode)
			STALL_NONE:     out_stall = 1'b0;
			STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < 35);
			STALL_PERIODIC: out_stall = ((stall_tick % 7) >= 4);
			default:        out_stall = ($urandom_range(0, 99) < 75);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_res = {event_res, field_tag, field_byte, field_end, photo_step, new_cycle,
				announced_len, len_mismatch};
			if (predicted_out.size() == 0) begin
				err_count++;
				$display("%0t: result with none pending: ev %0d tag %0d byte %02h", $time,
					event_res, field_tag, field_byte);
			end else begin
				want_res = predicted_out.pop_front();
				results_checked++;
				if (got_res !== want_res) begin
					err_count++;
					$display("%0t: mismatch exp/act ev %0d/%0d tag %0d/%0d byte %02h/%02h",
						$time, want_res.event_res, got_res.event_res,
						want_res.field_tag, got_res.field_tag,
						want_res.field_byte, got_res.field_byte);
					$display("%0t: mismatch exp/act end %0d/%0d step %0d/%0d new %0d/%0d",
						$time, want_res.field_end, got_res.field_end,
						want_res.photo_step, got_res.photo_step,
						want_res.new_cycle, got_res.new_cycle);
					$display("%0t: mismatch exp/act len %0d/%0d mism %0d/%0d",
						$time, want_res.announced_len, got_res.announced_len,
						want_res.len_mismatch, got_res.len_mismatch);
				end
				case (want_res.event_res)
					EV_ACK:    ack_seen++;
					EV_NAK:    nak_seen++;
					EV_STATUS: status_seen++;
					default:   ;
				endcase
				if (want_res.new_cycle)
					restart_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, predicted_out.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (gap_on && burst_left == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			in_valid = 1'b0;
			rx_byte = 8'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted_out.push_back(parse_byte(b));
		bytes_sent++;
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic shuffle_idling();
		stall_mode = stall_mode_t'($urandom_range(0, 3));
		gap_on = 1'($urandom_range(0, 1));
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_STX || b == CH_ETX);
		return b;
	endfunction

	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_STX || b == CH_ETX || b == CH_NUL || b == CH_PLUS
			|| char_numeral(b) || char_blank(b));
		return b;
	endfunction

	function automatic logic [7:0] lead_blank();
		case ($urandom_range(0, 7))
			0:       return CH_SPACE;
			1:       return CH_NUL;
			2:       return CH_TAB;
			3:       return 8'h0A;
			4:       return 8'h0B;
			5:       return 8'h0C;
			6:       return CH_CR;
			default: return CH_PLUS;
		endcase
	endfunction

	function automatic logic [15:0] step_chars(input step_form_t f, input int v);
		logic [7:0] c0;
		logic [7:0] c1;
		case (f)
			SF_TWO_DIGIT: begin
				c0 = DIGIT_BASE + 8'(v / 10);
				c1 = DIGIT_BASE + 8'(v % 10);
			end
			SF_LEAD_BLANK: begin
				c0 = lead_blank();
				c1 = DIGIT_BASE + 8'(v % 10);
			end
			SF_TRAIL_JUNK: begin
				c0 = DIGIT_BASE + 8'(v % 10);
				c1 = junk_byte();
			end
			SF_JUNK: begin
				c0 = junk_byte();
				c1 = body_byte();
			end
			default: begin
				c0 = body_byte();
				c1 = body_byte();
			end
		endcase
		return {c0, c1};
	endfunction

	function automatic logic [15:0] pick_step();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return step_chars(SF_TWO_DIGIT, $urandom_range(0, 19));
		return step_chars(step_form_t'(r - 5), $urandom_range(0, 19));
	endfunction

	task automatic add_byte(input logic [7:0] b);
		frame_bytes.push_back(b);
		frame_acc = frame_acc ^ b;
	endtask

	task automatic build_record(input int announced, input int data_n,
		input logic [15:0] step_pair);
		frame_bytes.delete();
		frame_acc = '0;
		frame_bytes.push_back(CH_STX);
		add_byte(DIGIT_BASE + 8'(announced / 100));
		add_byte(DIGIT_BASE + 8'((announced / 10) % 10));
		add_byte(DIGIT_BASE + 8'(announced % 10));
		add_byte(body_byte());
		repeat (BODY_FIXED) add_byte(body_byte());
		add_byte(step_pair[15:8]);
		add_byte(step_pair[7:0]);
		add_byte(body_byte());
		repeat (data_n) add_byte(body_byte());
		add_byte(CH_ETX);
		frame_bytes.push_back(frame_acc);
	endtask

	task automatic build_status_request(input int extras, input bit bad_check);
		frame_bytes.delete();
		frame_acc = '0;
		frame_bytes.push_back(CH_STX);
		add_byte(STATUS_CHAR);
		repeat (extras) add_byte(body_byte());
		// the parser takes the check byte itself once nine bytes are in
		if (extras < 8)
			add_byte(CH_ETX);
		frame_bytes.push_back(bad_check ? frame_acc ^ 8'($urandom_range(1, 255)) : frame_acc);
	endtask

	task automatic send_frame(input int inject_at, input logic [7:0] inject_byte,
		input int stop_at);
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if (i == stop_at)
				break;
			if (i == inject_at)
				send_byte(inject_byte);
			send_byte(frame_bytes[i]);
		end
		frames_sent++;
	endtask

	task automatic send_record(input int announced, input int data_n,
		input logic [15:0] step_pair);
		shuffle_idling();
		build_record(announced, data_n, step_pair);
		send_frame(-1, 8'h00, -1);
	endtask

	task automatic test_directed_cases();
		stall_mode = STALL_NONE;
		gap_on = 1'b0;
		frame_bytes = '{CH_ETX, 8'hFF, CH_NUL,
			CH_STX, STATUS_CHAR, CH_ETX, 8'h42,
			CH_STX, 8'h31, 8'h78,
			CH_STX, 8'h35, STATUS_CHAR,
			CH_STX, 8'h39, CH_STX, 8'h30, CH_ETX, 8'h33,
			CH_STX, STATUS_CHAR, 8'h40, CH_ETX, CH_STX};
		send_frame(-1, 8'h00, -1);
	endtask

	task automatic test_full_records();
		int n;
		for (int i = 0; i < 16; i++) begin
			n = $urandom_range(0, 24);
			if ($urandom_range(0, 4) == 0)
				send_record($urandom_range(0, 999), n, pick_step());
			else
				send_record(HEADER_BYTES + n, n, pick_step());
		end
	endtask

	task automatic test_length_extremes();
		send_record(0, 2, step_chars(SF_TWO_DIGIT, 5));
		send_record(999, 3, step_chars(SF_TWO_DIGIT, 16));
		send_record(HEADER_BYTES + 60, 60, step_chars(SF_TWO_DIGIT, 1));
		send_record(HEADER_BYTES + 2, 12, step_chars(SF_TWO_DIGIT, 9));
		send_record(HEADER_BYTES, 0, step_chars(SF_TWO_DIGIT, 10));
		send_record(HEADER_BYTES + 40, 5, step_chars(SF_TWO_DIGIT, 3));
	endtask

	task automatic test_photo_steps();
		logic [15:0] sp;
		for (int i = 0; i < 12; i++) begin
			case (i)
				0, 1, 2, 3: sp = step_chars(SF_TWO_DIGIT, 4 * i + 4);
				4:          sp = step_chars(SF_TWO_DIGIT, 2);
				5:          sp = step_chars(SF_LEAD_BLANK, $urandom_range(1, 9));
				6:          sp = step_chars(SF_TRAIL_JUNK, $urandom_range(0, 9));
				7:          sp = step_chars(SF_JUNK, 0);
				8:          sp = step_chars(SF_TWO_DIGIT, 0);
				9:          sp = step_chars(SF_TWO_DIGIT, 17);
				default:    sp = pick_step();
			endcase
			send_record(HEADER_BYTES + 1, 1, sp);
		end
	endtask

	task automatic test_status_requests();
		for (int i = 0; i < 25; i++) begin
			shuffle_idling();
			build_status_request((i < 9) ? i : $urandom_range(0, 8), $urandom_range(0, 5) == 0);
			send_frame(-1, 8'h00, -1);
		end
	endtask

	task automatic test_broken_frames();
		int n;
		int last;
		for (int i = 0; i < 10; i++) begin
			shuffle_idling();
			n = $urandom_range(0, 10);
			build_record(HEADER_BYTES + n, n, pick_step());
			last = frame_bytes.size() - 1;
			case (i % 5)
				0: send_frame(-1, 8'h00, $urandom_range(1, last));
				1: begin
					frame_bytes[last] = frame_bytes[last] ^ 8'($urandom_range(1, 255));
					send_frame(-1, 8'h00, -1);
				end
				2: begin
					frame_bytes[$urandom_range(1, 3)] = junk_byte();
					send_frame(-1, 8'h00, -1);
				end
				3: send_frame($urandom_range(2, last - 1), CH_ETX, -1);
				default: send_frame($urandom_range(1, last - 1), CH_STX, -1);
			endcase
		end
	endtask

	task automatic test_line_noise();
		int r;
		shuffle_idling();
		for (int i = 0; i < 120; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				send_byte(CH_STX);
			else if (r == 1)
				send_byte(CH_ETX);
			else
				send_byte(8'($urandom_range(0, 255)));
		end
		send_record(HEADER_BYTES + 4, 4, pick_step());
	endtask

	task automatic finish_run();
		@(negedge clk);
		in_valid = 1'b0;
		while (predicted_out.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d bytes in %0d frames; %0d results checked, %0d mismatches.",
			bytes_sent, frames_sent, results_checked, err_count);
		$display("Responses: %0d ACK, %0d NAK, %0d status answers, %0d photo cycle restarts.",
			ack_seen, nak_seen, status_seen, restart_seen);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		stall_mode = STALL_NONE;
		gap_on = 1'b0;
		burst_left = 0;
		stall_tick = 0;
		cycle_count = 0;
		err_count = 0;
		bytes_sent = 0;
		frames_sent = 0;
		results_checked = 0;
		ack_seen = 0;
		nak_seen = 0;
		status_seen = 0;
		restart_seen = 0;
		rec_phase = PH_IDLE;
		clear_record();
		prev_step = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_full_records();
		test_length_extremes();
		test_photo_steps();
		test_status_requests();
		test_broken_frames();
		test_line_noise();
		finish_run();
	end

endmodule

// ----- framed_record_receiver.f -----
hw/rtl/frr_pkg.sv
hw/rtl/frr_parser.sv
hw/rtl/framed_record_receiver.sv
tb/tb_framed_record_receiver.sv
